// File: hw/rtl/cmt_pkg.sv
// ----------------------------------------------------------------------------
// cmt_pkg
// Shared types, codes and range helpers of the checked tagged integer ALU.
// ----------------------------------------------------------------------------
package cmt_pkg;

  localparam int DATA_W     = 63;
  localparam int DIV_W      = 63;
  localparam int FIFO_DEPTH = 4;
  localparam int MUL_IDX    = 4;

  localparam logic [3:0] OP_ADD = 4'd0;
  localparam logic [3:0] OP_SUB = 4'd1;
  localparam logic [3:0] OP_MUL = 4'd2;
  localparam logic [3:0] OP_DIV = 4'd3;
  localparam logic [3:0] OP_MOD = 4'd4;
  localparam logic [3:0] OP_LSH = 4'd5;
  localparam logic [3:0] OP_RSH = 4'd6;
  localparam logic [3:0] OP_NEG = 4'd7;
  localparam logic [3:0] OP_POS = 4'd8;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_OVF   = 2'd1;
  localparam logic [1:0] ST_DIV0  = 2'd2;
  localparam logic [1:0] ST_NEGSH = 2'd3;

  typedef struct packed {
    logic [3:0]         op;
    logic [1:0]         st;
    logic signed [63:0] a;
    logic signed [63:0] b;
  } fe_word_t;

  typedef struct packed {
    logic [3:0]  op;
    logic [1:0]  st;
    logic [62:0] res;
    logic        neg_a;
    logic        neg_b;
  } bk_item_t;

  function automatic logic signed [63:0] smi_max_f(input int tag);
    int bits;
    bits = (tag >= 2) ? (64 - tag) : 63;
    return (64'sd1 <<< (bits - 1)) - 64'sd1;
  endfunction

  function automatic logic in_range_f(input logic signed [63:0] v, input int tag);
    logic signed [63:0] mx;
    mx = smi_max_f(tag);
    return (v >= (-mx - 64'sd1)) && (v <= mx);
  endfunction

endpackage

// File: hw/rtl/cmt_front.sv
// ----------------------------------------------------------------------------
// cmt_front
// Operand swap, range checks and early status classification.
// ----------------------------------------------------------------------------
module cmt_front #(
  parameter int TAG_BITS = 1
) (
  input  logic [3:0]        operation_i,
  input  logic              swap_operands_i,
  input  logic [62:0]       left_operand_i,
  input  logic [62:0]       right_operand_i,
  output cmt_pkg::fe_word_t word_o
);

  logic signed [63:0] x, y, a, b;
  logic               unary;
  logic [1:0]         st;

  always_comb begin
    x     = {left_operand_i[62], left_operand_i};
    y     = {right_operand_i[62], right_operand_i};
    unary = (operation_i == cmt_pkg::OP_NEG) || (operation_i == cmt_pkg::OP_POS);
    a     = (swap_operands_i && !unary) ? y : x;
    b     = (swap_operands_i && !unary) ? x : y;
    st    = cmt_pkg::ST_OK;
    if (operation_i > cmt_pkg::OP_POS) begin
      st = cmt_pkg::ST_OVF;
    end else if (!cmt_pkg::in_range_f(a, TAG_BITS) ||
                 (!unary && !cmt_pkg::in_range_f(b, TAG_BITS))) begin
      st = cmt_pkg::ST_OVF;
    end else if ((operation_i == cmt_pkg::OP_DIV || operation_i == cmt_pkg::OP_MOD) &&
                 b == 64'sd0) begin
      st = cmt_pkg::ST_DIV0;
    end else if ((operation_i == cmt_pkg::OP_LSH || operation_i == cmt_pkg::OP_RSH) &&
                 b[63]) begin
      st = cmt_pkg::ST_NEGSH;
    end else if (operation_i == cmt_pkg::OP_LSH && b[62:6] != '0) begin
      st = cmt_pkg::ST_OVF;
    end
    word_o.op = operation_i;
    word_o.st = st;
    word_o.a  = a;
    word_o.b  = b;
  end

endmodule

// File: hw/rtl/cmt_fifo.sv
// ----------------------------------------------------------------------------
// cmt_fifo
// Short queue that decouples the classifier from the execution pipeline.
// ----------------------------------------------------------------------------
module cmt_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  cmt_pkg::fe_word_t word_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              valid_o,
  output cmt_pkg::fe_word_t word_o
);

  localparam int PW = $clog2(cmt_pkg::FIFO_DEPTH);

  cmt_pkg::fe_word_t mem_q [cmt_pkg::FIFO_DEPTH];
  logic [PW-1:0]     wr_q, wr_d, rd_q, rd_d;
  logic [PW:0]       cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign full_o  = (cnt_q == (PW+1)'(cmt_pkg::FIFO_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign word_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_d  = do_push ? wr_q + PW'(1) : wr_q;
    rd_d  = do_pop ? rd_q + PW'(1) : rd_q;
    cnt_d = cnt_q + (PW+1)'(do_push) - (PW+1)'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= word_i;
    end
  end

endmodule

// File: hw/rtl/cmt_back.sv
// ----------------------------------------------------------------------------
// cmt_back
// Execution pipeline: simple ops, split multiplier, one-bit-per-stage divider.
// ----------------------------------------------------------------------------
module cmt_back #(
  parameter int TAG_BITS = 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              word_valid_i,
  input  cmt_pkg::fe_word_t word_i,
  output logic              word_pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [62:0]       result_value_o,
  output logic [1:0]        status_o
);

  localparam int N       = cmt_pkg::DIV_W;
  localparam int LS_KEEP = 63 - TAG_BITS;
  localparam logic signed [63:0] SMI_MAX = cmt_pkg::smi_max_f(TAG_BITS);

  logic adv;

  logic [N:0]        vld_q;
  cmt_pkg::bk_item_t it_q [0:N];
  cmt_pkg::bk_item_t it0_d, it4_d;

  logic [62:0] dv_rem_q [0:N];
  logic [62:0] dv_nq_q  [0:N];
  logic [62:0] dv_den_q [0:N];
  logic [62:0] dv_rem_d [1:N];
  logic [62:0] dv_nq_d  [1:N];

  logic [63:0]  pp_ll_q;
  logic [62:0]  pp_lh_q, pp_hl_q;
  logic [61:0]  pp_hh_q;
  logic [63:0]  ll2_q;
  logic [64:0]  mid_q;
  logic [61:0]  hh2_q;
  logic [125:0] p_q;

  logic               out_vld_q;
  logic [62:0]        out_res_q, out_res_d;
  logic [1:0]         out_st_q, out_st_d;

  logic signed [63:0]  a, b, r;
  logic signed [127:0] sh, sh_hi;
  logic [62:0]         a_mag, b_mag;

  assign adv            = !out_vld_q || out_ready_i;
  assign word_pop_o     = adv && word_valid_i;
  assign out_valid_o    = out_vld_q;
  assign result_value_o = out_res_q;
  assign status_o       = out_st_q;

  // stage 0: simple operations
  always_comb begin
    a     = word_i.a;
    b     = word_i.b;
    a_mag = a[63] ? 63'(-a) : a[62:0];
    b_mag = b[63] ? 63'(-b) : b[62:0];
    sh    = $signed({{64{a[63]}}, a}) <<< b[5:0];
    sh_hi = sh >>> LS_KEEP;
    r     = '0;
    it0_d.op    = word_i.op;
    it0_d.st    = word_i.st;
    it0_d.neg_a = a[63];
    it0_d.neg_b = b[63];
    case (word_i.op)
      cmt_pkg::OP_ADD: r = a + b;
      cmt_pkg::OP_SUB: r = a - b;
      cmt_pkg::OP_NEG: r = -a;
      cmt_pkg::OP_POS: r = a;
      cmt_pkg::OP_RSH: r = (b[62:6] != '0) ? $signed({64{a[63]}}) : (a >>> b[5:0]);
      cmt_pkg::OP_LSH: r = {{1{sh[62]}}, sh[62:0]};
      default:         r = '0;
    endcase
    if (word_i.st == cmt_pkg::ST_OK) begin
      if (word_i.op == cmt_pkg::OP_LSH) begin
        if (!(sh_hi == '0 || sh_hi == '1)) it0_d.st = cmt_pkg::ST_OVF;
      end else if (!cmt_pkg::in_range_f(r, TAG_BITS)) begin
        it0_d.st = cmt_pkg::ST_OVF;
      end
    end
    it0_d.res = r[62:0];
  end

  // divider stages: one quotient bit each
  always_comb begin
    for (int k = 1; k <= N; k++) begin
      logic [63:0] t;
      logic        ge;
      t  = {dv_rem_q[k-1], dv_nq_q[k-1][62]};
      ge = (t >= {1'b0, dv_den_q[k-1]});
      dv_rem_d[k] = ge ? 63'(t - {1'b0, dv_den_q[k-1]}) : t[62:0];
      dv_nq_d[k]  = {dv_nq_q[k-1][61:0], ge};
    end
  end

  // multiply result check
  always_comb begin
    logic        neg;
    logic [63:0] lim;
    logic [63:0] pr;
    it4_d = it_q[cmt_pkg::MUL_IDX-1];
    neg   = it4_d.neg_a ^ it4_d.neg_b;
    lim   = SMI_MAX + 64'(neg);
    pr    = neg ? -p_q[63:0] : p_q[63:0];
    if (it4_d.op == cmt_pkg::OP_MUL && it4_d.st == cmt_pkg::ST_OK) begin
      if (p_q[125:64] != '0 || p_q[63:0] > lim) begin
        it4_d.st = cmt_pkg::ST_OVF;
      end else begin
        it4_d.res = pr[62:0];
      end
    end
  end

  // final stage: floor fixup of quotient and remainder
  always_comb begin
    cmt_pkg::bk_item_t  it;
    logic [62:0]        qq, rr, dd;
    logic               diff, rnz;
    logic [63:0]        qm, mm;
    logic signed [63:0] v;
    it   = it_q[N];
    qq   = dv_nq_q[N];
    rr   = dv_rem_q[N];
    dd   = dv_den_q[N];
    diff = it.neg_a ^ it.neg_b;
    rnz  = (rr != '0);
    qm   = {1'b0, qq} + 64'(diff && rnz);
    mm   = (diff && rnz) ? {1'b0, dd} - {1'b0, rr} : {1'b0, rr};
    v    = '0;
    out_st_d  = it.st;
    out_res_d = it.res;
    if (it.st == cmt_pkg::ST_OK &&
        (it.op == cmt_pkg::OP_DIV || it.op == cmt_pkg::OP_MOD)) begin
      if (it.op == cmt_pkg::OP_DIV) v = diff ? -qm : qm;
      else v = it.neg_b ? -mm : mm;
      if (cmt_pkg::in_range_f(v, TAG_BITS)) out_res_d = v[62:0];
      else out_st_d = cmt_pkg::ST_OVF;
    end
    if (out_st_d != cmt_pkg::ST_OK) out_res_d = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else if (adv) begin
      vld_q     <= {vld_q[N-1:0], word_pop_o};
      out_vld_q <= vld_q[N];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      it_q[0]     <= it0_d;
      dv_rem_q[0] <= '0;
      dv_nq_q[0]  <= a_mag;
      dv_den_q[0] <= b_mag;
      for (int k = 1; k <= N; k++) begin
        it_q[k]     <= (k == cmt_pkg::MUL_IDX) ? it4_d : it_q[k-1];
        dv_rem_q[k] <= dv_rem_d[k];
        dv_nq_q[k]  <= dv_nq_d[k];
        dv_den_q[k] <= dv_den_q[k-1];
      end
      pp_ll_q   <= dv_nq_q[0][31:0] * dv_den_q[0][31:0];
      pp_lh_q   <= dv_nq_q[0][31:0] * dv_den_q[0][62:32];
      pp_hl_q   <= dv_nq_q[0][62:32] * dv_den_q[0][31:0];
      pp_hh_q   <= dv_nq_q[0][62:32] * dv_den_q[0][62:32];
      ll2_q     <= pp_ll_q;
      mid_q     <= {2'b0, pp_lh_q} + {2'b0, pp_hl_q};
      hh2_q     <= pp_hh_q;
      p_q       <= {62'b0, ll2_q} + {29'b0, mid_q, 32'b0} + {hh2_q, 64'b0};
      out_res_q <= out_res_d;
      out_st_q  <= out_st_d;
    end
  end

endmodule

// File: hw/rtl/checked_tagged_int_alu_unit.sv
// ----------------------------------------------------------------------------
// checked_tagged_int_alu_unit
// Checked integer ALU for the tagged small-integer range.
// ----------------------------------------------------------------------------
// One word in, one word out. A new word is taken every cycle while the queue
// is not full; each word passes the first execution stage, 63 divider stages
// and the output register in turn, a depth set by the 63-stage restoring
// divider, one quotient bit per stage. The multiplier uses four partial products
// of 32- and 31-bit operand halves over three stages inside the same pipeline.
// Output stalls freeze the pipeline; the 4-word queue keeps taking input until full.
module checked_tagged_int_alu_unit #(
  parameter int TAG_BITS = 1
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // [3:0] operation, [4] swap_operands, [67:5] left_operand,
  // [130:68] right_operand
  input  logic [135:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [62:0] result_value, [64:63] status
  output logic [71:0]  m_axis_tdata
);

  cmt_pkg::fe_word_t fe_word, q_word;
  logic              q_full, q_valid, q_pop;
  logic [62:0]       res_val;
  logic [1:0]        res_st;

  cmt_front #(.TAG_BITS(TAG_BITS)) u_front (
    .operation_i     (s_axis_tdata[3:0]),
    .swap_operands_i (s_axis_tdata[4]),
    .left_operand_i  (s_axis_tdata[67:5]),
    .right_operand_i (s_axis_tdata[130:68]),
    .word_o          (fe_word)
  );

  cmt_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (s_axis_tvalid),
    .word_i  (fe_word),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .word_o  (q_word)
  );

  cmt_back #(.TAG_BITS(TAG_BITS)) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .word_valid_i   (q_valid),
    .word_i         (q_word),
    .word_pop_o     (q_pop),
    .out_valid_o    (m_axis_tvalid),
    .out_ready_i    (m_axis_tready),
    .result_value_o (res_val),
    .status_o       (res_st)
  );

  assign s_axis_tready = !q_full;
  assign m_axis_tdata  = {7'b0, res_st, res_val};

`ifndef NO_ASSERTIONS
  a_err_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && res_st != cmt_pkg::ST_OK |-> res_val == '0)
    else $error("non-ok status with nonzero result");

  a_ok_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && res_st == cmt_pkg::ST_OK |->
      cmt_pkg::in_range_f({res_val[62], res_val}, TAG_BITS))
    else $error("ok result outside small-integer range");
`endif

endmodule

// File: sim/checked_tagged_int_alu_unit_tb.sv
// ----------------------------------------------------------------------------
// checked_tagged_int_alu_unit_tb
// Drives opcode/operand words into the checked ALU and compares every output
// word against table values or a behavioral predictor: directed corner rows
// first, then random words under three idling profiles.
// ----------------------------------------------------------------------------
module checked_tagged_int_alu_unit_tb;

  localparam int TAG = 1;
  localparam logic signed [63:0] SMAX = 64'sh3FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] SMIN = -SMAX - 64'sd1;

  typedef struct packed {
    logic [62:0] value;
    logic [1:0]  st;
  } alu_res_t;

  typedef struct {
    logic [3:0]  op;
    logic        swap;
    logic [62:0] lhs;
    logic [62:0] rhs;
    logic        known;
    logic [62:0] exp_val;
    logic [1:0]  exp_st;
  } stim_row_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [135:0] s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [71:0]  m_axis_tdata;

  alu_res_t expected_q[$];
  int       fail_cnt = 0;
  int       src_idle = 20;
  int       dst_idle = 45;

  checked_tagged_int_alu_unit #(.TAG_BITS(TAG)) u_top (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    #50_000_000;
    $display("Regression FAIL");
    $finish;
  end

  function automatic logic signed [63:0] sx(input logic [62:0] v);
    return {v[62], v};
  endfunction

  function automatic int sign_redundancy(input logic signed [63:0] x);
    logic [63:0] u;
    int n;
    u = x[63] ? ~x : x;
    n = 0;
    while (n < 64 && u[63-n] == 1'b0) n++;
    return n - 1;
  endfunction

  function automatic logic in_smi(input logic signed [63:0] v);
    return v >= SMIN && v <= SMAX;
  endfunction

  function automatic alu_res_t predict_alu(input logic [3:0] op, input logic swap,
                                           input logic [62:0] lhs, input logic [62:0] rhs);
    logic signed [63:0] a, b, r, q, m;
    logic signed [127:0] p;
    logic unary;
    alu_res_t o;
    unary = (op == cmt_pkg::OP_NEG) || (op == cmt_pkg::OP_POS);
    a = sx(lhs);
    b = sx(rhs);
    if (swap && !unary) begin
      a = sx(rhs);
      b = sx(lhs);
    end
    o.st = cmt_pkg::ST_OK;
    r = 0;
    if (op > cmt_pkg::OP_POS || !in_smi(a) || (!unary && !in_smi(b))) o.st = cmt_pkg::ST_OVF;
    else case (op) inside
      cmt_pkg::OP_ADD: r = a + b;
      cmt_pkg::OP_SUB: r = a - b;
      cmt_pkg::OP_MUL: begin
        p = 128'(a) * 128'(b);
        if (p > 128'(SMAX) || p < 128'(SMIN)) o.st = cmt_pkg::ST_OVF;
        else r = p[63:0];
      end
      cmt_pkg::OP_DIV, cmt_pkg::OP_MOD: begin
        if (b == 0) o.st = cmt_pkg::ST_DIV0;
        else if (op == cmt_pkg::OP_DIV && a == SMIN && b == -1) o.st = cmt_pkg::ST_OVF;
        else if (b == -1) r = (op == cmt_pkg::OP_DIV) ? -a : 0;
        else begin
          q = a / b;
          m = a % b;
          if (m != 0 && ((m < 0) != (b < 0))) begin
            q = q - 1;
            m = m + b;
          end
          r = (op == cmt_pkg::OP_DIV) ? q : m;
        end
      end
      cmt_pkg::OP_LSH: begin
        if (b < 0) o.st = cmt_pkg::ST_NEGSH;
        else if (b >= 64) o.st = cmt_pkg::ST_OVF;
        else if (a == 0) r = 0;
        else if (b + TAG > sign_redundancy(a)) o.st = cmt_pkg::ST_OVF;
        else r = a <<< b;
      end
      cmt_pkg::OP_RSH: begin
        if (b < 0) o.st = cmt_pkg::ST_NEGSH;
        else if (b >= 64) r = a[63] ? -64'sd1 : 64'sd0;
        else r = a >>> b;
      end
      cmt_pkg::OP_NEG: if (a == SMIN) o.st = cmt_pkg::ST_OVF; else r = -a;
      default: r = a;
    endcase
    if (o.st == cmt_pkg::ST_OK && !in_smi(r)) o.st = cmt_pkg::ST_OVF;
    o.value = (o.st == cmt_pkg::ST_OK) ? r[62:0] : '0;
    return o;
  endfunction

  task automatic send_word(input logic [3:0] op, input logic swap,
                           input logic [62:0] lhs, input logic [62:0] rhs,
                           input alu_res_t exp);
    while ($urandom_range(99) < src_idle) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {5'd0, rhs, lhs, swap, op};
    expected_q.push_back(exp);
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) m_axis_tready <= ($urandom_range(99) >= dst_idle);
  end

  always @(posedge clk_i) begin
    alu_res_t got, exp;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.value = m_axis_tdata[62:0];
      got.st    = m_axis_tdata[64:63];
      if (expected_q.size() == 0) begin
        $error("unexpected output word %h", m_axis_tdata);
        fail_cnt++;
      end else begin
        exp = expected_q.pop_front();
        if (got.st != exp.st) begin
          $error("status exp %0d got %0d", exp.st, got.st);
          fail_cnt++;
        end
        if (got.value != exp.value) begin
          $error("result_value exp %h got %h", exp.value, got.value);
          fail_cnt++;
        end
      end
    end
  end

  function automatic logic [62:0] rand_operand(input int shift_like);
    logic [62:0] v;
    case ($urandom_range(7))
      0: v = 63'({$urandom, $urandom});
      1: v = 63'($urandom_range(70));
      2: v = -63'($urandom_range(70));
      3: v = shift_like ? 63'($urandom_range(64)) : 63'(sx(63'($urandom)) >>> $urandom_range(31));
      4: v = $urandom_range(1) ? SMAX[62:0] : SMIN[62:0];
      5: v = 63'(64'($urandom) << $urandom_range(31));
      default: v = 63'(sx(63'({$urandom, $urandom})) >>> $urandom_range(62));
    endcase
    return v;
  endfunction

  stim_row_t dir_tbl[] = '{
    '{cmt_pkg::OP_ADD, 0, SMAX[62:0], 63'd1, 1, 63'd0, cmt_pkg::ST_OVF},
    '{cmt_pkg::OP_ADD, 0, SMIN[62:0], -63'd1, 1, 63'd0, cmt_pkg::ST_OVF},
    '{cmt_pkg::OP_ADD, 1, SMAX[62:0], SMIN[62:0], 1, -63'd1, cmt_pkg::ST_OK},
    '{cmt_pkg::OP_SUB, 0, SMIN[62:0], 63'd1, 1, 63'd0, cmt_pkg::ST_OVF},
    '{cmt_pkg::OP_SUB, 1, 63'd3, 63'd10, 0, 0, 0},
    '{cmt_pkg::OP_MUL, 0, SMIN[62:0], 63'd1, 1, SMIN[62:0], cmt_pkg::ST_OK},
    '{cmt_pkg::OP_MUL, 0, SMIN[62:0], -63'd1, 1, 63'd0, cmt_pkg::ST_OVF},
    '{cmt_pkg::OP_MUL, 0, 63'h4000_0000, -63'h1_0000_0000, 0, 0, 0},
    '{cmt_pkg::OP_DIV, 0, 63'd7, 63'd0, 1, 63'd0, cmt_pkg::ST_DIV0},
    '{cmt_pkg::OP_DIV, 0, SMIN[62:0], -63'd1, 1, 63'd0, cmt_pkg::ST_OVF},
    '{cmt_pkg::OP_DIV, 0, -63'd7, 63'd2, 1, -63'd4, cmt_pkg::ST_OK},
    '{cmt_pkg::OP_DIV, 1, 63'd2, 63'd7, 0, 0, 0},
    '{cmt_pkg::OP_MOD, 0, 63'd7, 63'd0, 1, 63'd0, cmt_pkg::ST_DIV0},
    '{cmt_pkg::OP_MOD, 0, 63'd7, -63'd2, 1, -63'd1, cmt_pkg::ST_OK},
    '{cmt_pkg::OP_MOD, 0, SMIN[62:0], -63'd1, 1, 63'd0, cmt_pkg::ST_OK},
    '{cmt_pkg::OP_LSH, 0, 63'd1, -63'd1, 1, 63'd0, cmt_pkg::ST_NEGSH},
    '{cmt_pkg::OP_LSH, 0, 63'd0, 63'd64, 1, 63'd0, cmt_pkg::ST_OVF},
    '{cmt_pkg::OP_LSH, 0, 63'd0, 63'd63, 1, 63'd0, cmt_pkg::ST_OK},
    '{cmt_pkg::OP_LSH, 0, 63'd1, 63'd61, 0, 0, 0},
    '{cmt_pkg::OP_LSH, 1, 63'd62, -63'd1, 0, 0, 0},
    '{cmt_pkg::OP_RSH, 0, -63'd5, 63'd64, 1, -63'd1, cmt_pkg::ST_OK},
    '{cmt_pkg::OP_RSH, 0, 63'd5, -63'd2, 1, 63'd0, cmt_pkg::ST_NEGSH},
    '{cmt_pkg::OP_NEG, 1, SMIN[62:0], 63'd5, 1, 63'd0, cmt_pkg::ST_OVF},
    '{cmt_pkg::OP_POS, 1, SMAX[62:0], 63'd0, 1, SMAX[62:0], cmt_pkg::ST_OK},
    '{4'd15, 0, 63'd1, 63'd1, 1, 63'd0, cmt_pkg::ST_OVF}
  };

  initial begin
    alu_res_t exp;
    logic [3:0] op;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (dir_tbl[i]) begin
      if (dir_tbl[i].known) begin
        exp.value = dir_tbl[i].exp_val;
        exp.st    = dir_tbl[i].exp_st;
      end else begin
        exp = predict_alu(dir_tbl[i].op, dir_tbl[i].swap, dir_tbl[i].lhs, dir_tbl[i].rhs);
      end
      send_word(dir_tbl[i].op, dir_tbl[i].swap, dir_tbl[i].lhs, dir_tbl[i].rhs, exp);
    end
    for (int ph = 0; ph < 3; ph++) begin
      src_idle = (ph == 0) ? 20 : (ph == 1) ? 45 : 0;
      dst_idle = (ph == 0) ? 45 : (ph == 1) ? 20 : 0;
      for (int n = 0; n < 250; n++) begin
        logic [62:0] l, r;
        logic sw;
        op = ($urandom_range(19) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(8));
        sw = 1'($urandom_range(1));
        l  = rand_operand(sw && (op == cmt_pkg::OP_LSH || op == cmt_pkg::OP_RSH));
        r  = rand_operand(!sw && (op == cmt_pkg::OP_LSH || op == cmt_pkg::OP_RSH));
        send_word(op, sw, l, r, predict_alu(op, sw, l, r));
      end
    end
    s_axis_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (fail_cnt == 0 && expected_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
